// ===== rtl/array_list_insert_delete_core_defines.svh =====
// Assertion macros for the array list core.
// Used by the top level only; no other dependencies.
`ifndef ARRAY_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define ARRAY_LIST_INSERT_DELETE_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define ALID_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ALID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/alid_pkg.sv =====
// Package for the array list core: sizes, operation and status codes, decode plan.
// No dependencies.
`default_nettype none

package alid_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    size_next;
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic                rd_en;
        logic                shift_up;
        logic                shift_down;
        logic [CNT_W-1:0]    moves;
        logic [ADDR_W-1:0]   src_start;
    } plan_t;

endpackage

`default_nettype wire

// ===== rtl/alid_req_if.sv =====
// Request channel of the array list core: valid/ready plus operation payload.
// Depends on alid_pkg.
`default_nettype none

interface alid_req_if;
    logic                                valid;
    logic                                ready;
    logic [alid_pkg::KIND_W-1:0]         kind;
    logic [alid_pkg::ADDR_W-1:0]         position;
    logic signed [alid_pkg::VALUE_W-1:0] value;

    modport source (output valid, output kind, output position, output value, input ready);
    modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/alid_rsp_if.sv =====
// Response channel of the array list core: valid/ready plus result payload.
// Depends on alid_pkg.
`default_nettype none

interface alid_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [alid_pkg::VALUE_W-1:0]  read_value;
    logic [alid_pkg::STATUS_W-1:0]        status;
    logic [alid_pkg::CNT_W-1:0]           size;

    modport source (output valid, output read_value, output status, output size, input ready);
    modport sink   (input valid, input read_value, input status, input size, output ready);
endinterface

`default_nettype wire

// ===== rtl/array_list_insert_delete_core.sv =====
// Top level of the array list core: sequencer, entry RAM, count and result register.
// Depends on alid_pkg, alid_req_if, alid_rsp_if, alid_ram, alid_decode and the defines header.
//
//  Channel | Role   | Payload                              | Handshake
//  --------+--------+--------------------------------------+-------------
//  req     | sink   | kind[2:0] position[5:0] value[31:0]  | valid/ready
//  rsp     | source | read_value[31:0] status[1:0] size[6:0]| valid/ready
//
// Read, write, append, remove last and rejected operations go from IDLE straight to RESP.
// Insert and delete pass through SHIFT, moving count-position and count-position-1 entries: the
// single RAM write port moves one entry per cycle, the read of the next entry overlapped.
// Reset clears the count and control state; RAM contents stay undefined until written.
// A new request is taken once the previous one has left the sequencer, even while its
// result still waits in the output register; a stalled rsp holds the sequencer in RESP.
`default_nettype none
`include "array_list_insert_delete_core_defines.svh"

module array_list_insert_delete_core (
    input wire logic    clk,
    input wire logic    rst_n,
    alid_req_if.sink    req,
    alid_rsp_if.source  rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_RESP  = 2'd2;

    // sequencer state
    logic [1:0]                        state_reg, state_next;
    logic [alid_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [alid_pkg::STATUS_W-1:0]     pend_status_reg, pend_status_next;
    logic                              pend_read_reg, pend_read_next;
    logic                              up_reg, up_next;
    logic [alid_pkg::ADDR_W-1:0]       pos_reg, pos_next;
    logic [alid_pkg::VALUE_W-1:0]      val_reg, val_next;
    logic [alid_pkg::ADDR_W-1:0]       src_reg, src_next;
    logic [alid_pkg::ADDR_W-1:0]       dst_reg, dst_next;
    logic [alid_pkg::CNT_W-1:0]        left_reg, left_next;
    logic                              mv_valid_reg, mv_valid_next;

    // output register
    logic                              out_valid_reg, out_valid_next;
    logic [alid_pkg::VALUE_W-1:0]      out_value_reg, out_value_next;
    logic [alid_pkg::STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [alid_pkg::CNT_W-1:0]        out_size_reg, out_size_next;

    // RAM port signals
    logic                              ram_we;
    logic [alid_pkg::ADDR_W-1:0]       ram_waddr;
    logic [alid_pkg::VALUE_W-1:0]      ram_wdata;
    logic                              ram_re;
    logic [alid_pkg::ADDR_W-1:0]       ram_raddr;
    logic [alid_pkg::VALUE_W-1:0]      ram_rdata;

    alid_pkg::plan_t                   plan;
    logic                              req_fire;
    logic                              out_load;

    alid_decode u_decode (
        .kind     (req.kind),
        .position (req.position),
        .count    (count_reg),
        .plan     (plan)
    );

    alid_ram #(
        .DEPTH (alid_pkg::CAPACITY),
        .WIDTH (alid_pkg::VALUE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    // the result leaves RESP when the output register is empty or being drained
    assign out_load  = (state_reg == S_RESP) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        pend_read_next   = pend_read_reg;
        up_next          = up_reg;
        pos_next         = pos_reg;
        val_next         = val_reg;
        src_next         = src_reg;
        dst_next         = dst_reg;
        left_next        = left_reg;
        mv_valid_next    = mv_valid_reg;
        ram_we           = 1'b0;
        ram_waddr        = plan.wr_addr;
        ram_wdata        = req.value;
        ram_re           = 1'b0;
        ram_raddr        = req.position;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    // commit the count now; the RAM catches up during the shift
                    count_next       = plan.size_next;
                    pend_status_next = plan.status;
                    pend_read_next   = plan.rd_en;
                    up_next          = plan.shift_up;
                    pos_next         = req.position;
                    val_next         = req.value;
                    src_next         = plan.src_start;
                    left_next        = plan.moves;
                    mv_valid_next    = 1'b0;
                    ram_we           = plan.wr_en;
                    ram_re           = plan.rd_en;
                    if (plan.shift_up || plan.shift_down)
                        state_next = S_SHIFT;
                    else
                        state_next = S_RESP;
                end
            end
            S_SHIFT:
            begin
                // write back the entry read last cycle
                if (mv_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dst_reg;
                    ram_wdata = ram_rdata;
                end
                if (left_reg != '0)
                begin
                    // fetch the next entry to move
                    ram_re        = 1'b1;
                    ram_raddr     = src_reg;
                    dst_next      = up_reg ? src_reg + alid_pkg::ADDR_W'(1)
                                           : src_reg - alid_pkg::ADDR_W'(1);
                    src_next      = up_reg ? src_reg - alid_pkg::ADDR_W'(1)
                                           : src_reg + alid_pkg::ADDR_W'(1);
                    left_next     = left_reg - alid_pkg::CNT_W'(1);
                    mv_valid_next = 1'b1;
                end
                else
                begin
                    mv_valid_next = 1'b0;
                    if (!mv_valid_reg)
                    begin
                        // shift drained: an insert drops the new word into the gap
                        if (up_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pos_reg;
                            ram_wdata = val_reg;
                        end
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_size_next   = out_size_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            // read data stays in the RAM output register: no read is issued in RESP
            out_value_next  = pend_read_reg ? ram_rdata : '0;
            out_status_next = pend_status_reg;
            out_size_next   = count_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            mv_valid_reg  <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mv_valid_reg  <= mv_valid_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_read_reg   <= pend_read_next;
        up_reg          <= up_next;
        pos_reg         <= pos_next;
        val_reg         <= val_next;
        src_reg         <= src_next;
        dst_reg         <= dst_next;
        out_value_reg   <= out_value_next;
        out_status_reg  <= out_status_next;
        out_size_reg    <= out_size_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.size       = out_size_reg;

    `ALID_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= alid_pkg::CNT_W'(alid_pkg::CAPACITY), "count exceeds capacity")
    `ALID_ASSERT_NEXT(a_accept_busy, clk, rst_n, req_fire, state_reg != S_IDLE, "sequencer idle after accepting a transaction")
    `ALID_ASSERT_SAME(a_shift_no_clash, clk, rst_n, (state_reg == S_SHIFT) && ram_we && ram_re, ram_waddr != ram_raddr, "shift reads and writes the same entry")

endmodule

`default_nettype wire

// ===== rtl/alid_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module alid_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/alid_decode.sv =====
// Operation decode: checks an operation against the current count and plans it.
// Depends on alid_pkg.
`default_nettype none

module alid_decode (
    input  wire logic [alid_pkg::KIND_W-1:0] kind,
    input  wire logic [alid_pkg::ADDR_W-1:0] position,
    input  wire logic [alid_pkg::CNT_W-1:0]  count,
    output      alid_pkg::plan_t             plan
);

    logic [alid_pkg::CNT_W-1:0] pos_ext;
    logic                       in_range;
    logic                       is_full;
    logic                       is_empty;

    assign pos_ext  = alid_pkg::CNT_W'(position);
    assign in_range = pos_ext < count;
    assign is_full  = count >= alid_pkg::CNT_W'(alid_pkg::CAPACITY);
    assign is_empty = count == '0;

    always_comb
    begin
        plan            = '0;
        plan.status     = alid_pkg::ST_OK;
        plan.size_next  = count;
        plan.wr_addr    = position;
        plan.src_start  = position;
        case (kind)
            alid_pkg::KIND_READ:
            begin
                if (in_range)
                    plan.rd_en = 1'b1;
                else
                    plan.status = alid_pkg::ST_BADPOS;
            end
            alid_pkg::KIND_WRITE:
            begin
                if (in_range)
                    plan.wr_en = 1'b1;
                else
                    plan.status = alid_pkg::ST_BADPOS;
            end
            alid_pkg::KIND_APPEND:
            begin
                if (is_full)
                    plan.status = alid_pkg::ST_FULL;
                else
                begin
                    plan.wr_en     = 1'b1;
                    plan.wr_addr   = count[alid_pkg::ADDR_W-1:0];
                    plan.size_next = count + alid_pkg::CNT_W'(1);
                end
            end
            alid_pkg::KIND_REMOVE:
            begin
                if (is_empty)
                    plan.status = alid_pkg::ST_EMPTY;
                else
                    plan.size_next = count - alid_pkg::CNT_W'(1);
            end
            alid_pkg::KIND_INSERT:
            begin
                if (is_full)
                    plan.status = alid_pkg::ST_FULL;
                else if (!in_range)
                    plan.status = alid_pkg::ST_BADPOS;
                else
                begin
                    // move entries pos..count-1 up, from the top down
                    plan.shift_up  = 1'b1;
                    plan.moves     = count - pos_ext;
                    plan.src_start = count[alid_pkg::ADDR_W-1:0] - alid_pkg::ADDR_W'(1);
                    plan.size_next = count + alid_pkg::CNT_W'(1);
                end
            end
            alid_pkg::KIND_DELETE:
            begin
                if (is_empty)
                    plan.status = alid_pkg::ST_EMPTY;
                else if (!in_range)
                    plan.status = alid_pkg::ST_BADPOS;
                else
                begin
                    // move entries pos+1..count-1 down, from the bottom up
                    plan.shift_down = 1'b1;
                    plan.moves      = count - pos_ext - alid_pkg::CNT_W'(1);
                    plan.src_start  = position + alid_pkg::ADDR_W'(1);
                    plan.size_next  = count - alid_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                plan.status = alid_pkg::ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire
